### src/sov_pkg.sv
// ----------------------------------------------------------------------------
// sov_pkg
// shared types and constants of the slab outflux volume block
// ----------------------------------------------------------------------------
package sov_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_FACES      = 6;
   localparam int CSR_INDEX_W    = 2;

   // face order of the result stream
   typedef enum logic [2:0] {
      FACE_TOP    = 3'd0,
      FACE_BOTTOM = 3'd1,
      FACE_RIGHT  = 3'd2,
      FACE_LEFT   = 3'd3,
      FACE_FRONT  = 3'd4,
      FACE_BACK   = 3'd5
   } face_type;

   // register indexes of the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TIME_STEP   = 2'd0,
      REG_CELL_SIZE_X = 2'd1,
      REG_CELL_SIZE_Y = 2'd2,
      REG_CELL_SIZE_Z = 2'd3
   } reg_index_type;

   // control that travels with one face through the pipeline
   typedef struct packed {
      logic     valid;
      face_type face;
   } face_tag_type;

endpackage

### src/sov_qmul.sv
// ----------------------------------------------------------------------------
// sov_qmul
// two-stage saturating fixed-point multiply of two non-negative values
// ----------------------------------------------------------------------------
module sov_qmul
   import sov_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic [DATA_WIDTH-1:0] a,
   input  logic [DATA_WIDTH-2:0] b,
   output logic [DATA_WIDTH-2:0] q
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int HI = FRAC_BITS + DATA_WIDTH - 1;

   logic [PW-1:0]         prod_ff;
   logic [PW-1:0]         prod_in;
   logic [DATA_WIDTH-2:0] q_ff;
   logic [DATA_WIDTH-2:0] q_in;

   assign prod_in = PW'(a) * PW'(b);

   // anything above the result window means overflow
   always_comb begin
      if (prod_ff[PW-1:HI] != '0) begin
         q_in = '1;
      end else begin
         q_in = prod_ff[HI-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q_ff    <= q_in;
   end

   assign q = q_ff;

endmodule

### src/sov_cfg.sv
// ----------------------------------------------------------------------------
// sov_cfg
// configuration registers with derived face areas and cell volume
// ----------------------------------------------------------------------------
module sov_cfg
   import sov_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_WIDTH-2:0]  csr_wdata,
   output logic [DATA_WIDTH-2:0]  time_step,
   output logic [DATA_WIDTH-2:0]  size_x,
   output logic [DATA_WIDTH-2:0]  size_y,
   output logic [DATA_WIDTH-2:0]  size_z,
   output logic [DATA_WIDTH-2:0]  area_xz,
   output logic [DATA_WIDTH-2:0]  area_yz,
   output logic [DATA_WIDTH-2:0]  area_xy,
   output logic [DATA_WIDTH-2:0]  volume
);

   localparam logic [DATA_WIDTH-2:0] ONE = (DATA_WIDTH-1)'(1) << FRAC_BITS;

   logic [DATA_WIDTH-2:0] time_step_ff;
   logic [DATA_WIDTH-2:0] size_x_ff;
   logic [DATA_WIDTH-2:0] size_y_ff;
   logic [DATA_WIDTH-2:0] size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= ONE;
         size_x_ff    <= ONE;
         size_y_ff    <= ONE;
         size_z_ff    <= ONE;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_TIME_STEP:   time_step_ff <= csr_wdata;
            REG_CELL_SIZE_X: size_x_ff    <= csr_wdata;
            REG_CELL_SIZE_Y: size_y_ff    <= csr_wdata;
            REG_CELL_SIZE_Z: size_z_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // areas come from the size registers through one multiplier, volume through a second fed by area_xy
   sov_qmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_area_xz (
      .clock (clock),
      .a     ({1'b0, size_x_ff}),
      .b     (size_z_ff),
      .q     (area_xz)
   );

   sov_qmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_area_yz (
      .clock (clock),
      .a     ({1'b0, size_y_ff}),
      .b     (size_z_ff),
      .q     (area_yz)
   );

   sov_qmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_area_xy (
      .clock (clock),
      .a     ({1'b0, size_x_ff}),
      .b     (size_y_ff),
      .q     (area_xy)
   );

   sov_qmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_volume (
      .clock (clock),
      .a     ({1'b0, area_xy}),
      .b     (size_z_ff),
      .q     (volume)
   );

   assign time_step = time_step_ff;
   assign size_x    = size_x_ff;
   assign size_y    = size_y_ff;
   assign size_z    = size_z_ff;

endmodule

### src/sov_face_pipe.sv
// ----------------------------------------------------------------------------
// sov_face_pipe
// cell buffer, face issue sequencer, depth and flux multiply stages
// ----------------------------------------------------------------------------
module sov_face_pipe
   import sov_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATA_WIDTH-1:0] u_low_face,
   input  logic [DATA_WIDTH-1:0] u_high_face,
   input  logic [DATA_WIDTH-1:0] v_low_face,
   input  logic [DATA_WIDTH-1:0] v_high_face,
   input  logic [DATA_WIDTH-1:0] w_low_face,
   input  logic [DATA_WIDTH-1:0] w_high_face,
   input  logic [DATA_WIDTH-2:0] time_step,
   input  logic [DATA_WIDTH-2:0] area_xz,
   input  logic [DATA_WIDTH-2:0] area_yz,
   input  logic [DATA_WIDTH-2:0] area_xy,
   output face_tag_type          out_tag,
   output logic [DATA_WIDTH-2:0] out_depth,
   output logic [DATA_WIDTH-2:0] out_flux
);

   logic                  accept;
   logic                  seq_active_ff;
   face_type              seq_face_ff;
   logic [DATA_WIDTH-1:0] u_lo_ff, u_hi_ff, v_lo_ff, v_hi_ff, w_lo_ff, w_hi_ff;

   logic [DATA_WIDTH-1:0] vel;
   logic                  plus;
   logic                  neg;
   logic                  active;
   logic [DATA_WIDTH-1:0] mag_in;
   logic [DATA_WIDTH-1:0] mag_ff;

   face_tag_type          tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic [DATA_WIDTH-2:0] depth3;
   logic [DATA_WIDTH-2:0] dep4_ff, dep5_ff;
   logic [DATA_WIDTH-2:0] area_sel;

   // the last face issue frees the buffer for the next cell
   assign busy   = seq_active_ff && (seq_face_ff != FACE_BACK);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (accept) begin
         u_lo_ff <= u_low_face;
         u_hi_ff <= u_high_face;
         v_lo_ff <= v_low_face;
         v_hi_ff <= v_high_face;
         w_lo_ff <= w_low_face;
         w_hi_ff <= w_high_face;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_active_ff <= 1'b0;
         seq_face_ff   <= FACE_TOP;
      end else if (accept) begin
         seq_active_ff <= 1'b1;
         seq_face_ff   <= FACE_TOP;
      end else if (seq_active_ff) begin
         if (seq_face_ff == FACE_BACK) begin
            seq_active_ff <= 1'b0;
         end else begin
            seq_face_ff <= face_type'(seq_face_ff + 3'd1);
         end
      end
   end

   // high faces take +v, low faces -v
   always_comb begin
      unique case (seq_face_ff)
         FACE_TOP:    vel = v_hi_ff;
         FACE_BOTTOM: vel = v_lo_ff;
         FACE_RIGHT:  vel = u_hi_ff;
         FACE_LEFT:   vel = u_lo_ff;
         FACE_FRONT:  vel = w_hi_ff;
         FACE_BACK:   vel = w_lo_ff;
         default:     vel = '0;
      endcase
      plus   = !seq_face_ff[0];
      neg    = vel[DATA_WIDTH-1];
      active = plus ? (!neg && (vel != '0)) : neg;
      mag_in = active ? (neg ? (~vel + 1'b1) : vel) : '0;
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else begin
         tag1_ff <= '{valid: seq_active_ff, face: seq_face_ff};
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   sov_qmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_depth_mul (
      .clock (clock),
      .a     (mag_ff),
      .b     (time_step),
      .q     (depth3)
   );

   always_comb begin
      case (tag3_ff.face) inside
         FACE_TOP, FACE_BOTTOM:  area_sel = area_xz;
         FACE_RIGHT, FACE_LEFT:  area_sel = area_yz;
         default:                area_sel = area_xy;
      endcase
   end

   sov_qmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_flux_mul (
      .clock (clock),
      .a     ({1'b0, depth3}),
      .b     (area_sel),
      .q     (out_flux)
   );

   always_ff @(posedge clock) begin
      dep4_ff <= depth3;
      dep5_ff <= dep4_ff;
   end

   assign out_tag   = tag5_ff;
   assign out_depth = dep5_ff;

   // faces of a cell leave the issue stage on consecutive cycles
   a_faces_contiguous: assert property (@(posedge clock) disable iff (reset)
      tag1_ff.valid && (tag1_ff.face != FACE_TOP) |->
         $past(tag1_ff.valid) && ($past(tag1_ff.face) == face_type'(tag1_ff.face - 3'd1)))
      else $error("face issue order broken");

   // a new cell enters only after the back face of the previous one issued
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      accept && seq_active_ff |-> seq_face_ff == FACE_BACK)
      else $error("cell accepted over an unfinished sequence");

endmodule

### src/sov_collect.sv
// ----------------------------------------------------------------------------
// sov_collect
// gathers the six faces of a cell, forms the over-volume flag and
// plays the six results out with their slab centroids
// ----------------------------------------------------------------------------
module sov_collect
   import sov_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  face_tag_type          in_tag,
   input  logic [DATA_WIDTH-2:0] in_depth,
   input  logic [DATA_WIDTH-2:0] in_flux,
   input  logic [DATA_WIDTH-2:0] volume,
   input  logic [DATA_WIDTH-2:0] size_x,
   input  logic [DATA_WIDTH-2:0] size_y,
   input  logic [DATA_WIDTH-2:0] size_z,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_face_index,
   output logic [DATA_WIDTH-2:0] rsp_outflux_volume,
   output logic [DATA_WIDTH-1:0] rsp_centroid_x,
   output logic [DATA_WIDTH-1:0] rsp_centroid_y,
   output logic [DATA_WIDTH-1:0] rsp_centroid_z,
   output logic                  rsp_over_volume,
   output logic                  rsp_last_face
);

   logic [DATA_WIDTH-2:0] col_dep_ff  [NUM_FACES];
   logic [DATA_WIDTH-2:0] col_flux_ff [NUM_FACES];
   logic [DATA_WIDTH-2:0] total_ff;
   logic [DATA_WIDTH-1:0] sum;
   logic [DATA_WIDTH-2:0] total_in;
   logic                  complete;

   logic [DATA_WIDTH-2:0] ob_dep_ff  [NUM_FACES];
   logic [DATA_WIDTH-2:0] ob_flux_ff [NUM_FACES];
   logic                  ob_over_ff;
   logic                  out_active_ff;
   face_type              out_face_ff;

   logic [DATA_WIDTH-1:0] half [NUM_FACES];
   logic [DATA_WIDTH-1:0] hsx, hsy, hsz;
   logic [DATA_WIDTH-1:0] cx_in, cy_in, cz_in;
   logic [DATA_WIDTH-2:0] flux_sel;

   logic                  rsp_valid_ff;
   face_type              rsp_face_ff;
   logic [DATA_WIDTH-2:0] rsp_flux_ff;
   logic [DATA_WIDTH-1:0] rsp_cx_ff, rsp_cy_ff, rsp_cz_ff;
   logic                  rsp_over_ff;
   logic                  rsp_last_ff;

   // saturating running total, restarted by the top face
   always_comb begin
      sum      = (in_tag.face == FACE_TOP) ? {1'b0, in_flux}
                                           : {1'b0, total_ff} + {1'b0, in_flux};
      total_in = sum[DATA_WIDTH-1] ? '1 : sum[DATA_WIDTH-2:0];
      complete = in_tag.valid && (in_tag.face == FACE_BACK);
   end

   always_ff @(posedge clock) begin
      if (in_tag.valid) begin
         total_ff <= total_in;
         for (int i = 0; i < NUM_FACES; i++) begin
            if (in_tag.face == face_type'(i)) begin
               col_dep_ff[i]  <= in_depth;
               col_flux_ff[i] <= in_flux;
            end
         end
      end
   end

   // hand the finished cell to the playout buffer
   always_ff @(posedge clock) begin
      if (complete) begin
         for (int i = 0; i < NUM_FACES - 1; i++) begin
            ob_dep_ff[i]  <= col_dep_ff[i];
            ob_flux_ff[i] <= col_flux_ff[i];
         end
         ob_dep_ff[NUM_FACES-1]  <= in_depth;
         ob_flux_ff[NUM_FACES-1] <= in_flux;
         ob_over_ff              <= total_in > volume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_active_ff <= 1'b0;
         out_face_ff   <= FACE_TOP;
      end else if (complete) begin
         out_active_ff <= 1'b1;
         out_face_ff   <= FACE_TOP;
      end else if (out_active_ff) begin
         if (out_face_ff == FACE_BACK) begin
            out_active_ff <= 1'b0;
         end else begin
            out_face_ff <= face_type'(out_face_ff + 3'd1);
         end
      end
   end

   // centroids from halved depths and sizes, modulo 2^DATA_WIDTH
   always_comb begin
      for (int i = 0; i < NUM_FACES; i++) begin
         half[i] = {2'b00, ob_dep_ff[i][DATA_WIDTH-2:1]};
      end
      hsx   = {2'b00, size_x[DATA_WIDTH-2:1]};
      hsy   = {2'b00, size_y[DATA_WIDTH-2:1]};
      hsz   = {2'b00, size_z[DATA_WIDTH-2:1]};
      cx_in = half[FACE_LEFT] - half[FACE_RIGHT];
      cy_in = half[FACE_BOTTOM] - half[FACE_TOP];
      cz_in = half[FACE_BACK] - half[FACE_FRONT];
      unique case (out_face_ff)
         FACE_TOP: begin
            cy_in    = hsy - half[FACE_TOP];
            flux_sel = ob_flux_ff[FACE_TOP];
         end
         FACE_BOTTOM: begin
            cy_in    = half[FACE_BOTTOM] - hsy;
            flux_sel = ob_flux_ff[FACE_BOTTOM];
         end
         FACE_RIGHT: begin
            cx_in    = hsx - half[FACE_RIGHT];
            flux_sel = ob_flux_ff[FACE_RIGHT];
         end
         FACE_LEFT: begin
            cx_in    = half[FACE_LEFT] - hsx;
            flux_sel = ob_flux_ff[FACE_LEFT];
         end
         FACE_FRONT: begin
            cz_in    = hsz - half[FACE_FRONT];
            flux_sel = ob_flux_ff[FACE_FRONT];
         end
         FACE_BACK: begin
            cz_in    = half[FACE_BACK] - hsz;
            flux_sel = ob_flux_ff[FACE_BACK];
         end
         default: begin
            flux_sel = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= out_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_face_ff <= out_face_ff;
      rsp_flux_ff <= flux_sel;
      rsp_cx_ff   <= cx_in;
      rsp_cy_ff   <= cy_in;
      rsp_cz_ff   <= cz_in;
      rsp_over_ff <= ob_over_ff;
      rsp_last_ff <= (out_face_ff == FACE_BACK);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_face_index     = rsp_face_ff;
   assign rsp_outflux_volume = rsp_flux_ff;
   assign rsp_centroid_x     = rsp_cx_ff;
   assign rsp_centroid_y     = rsp_cy_ff;
   assign rsp_centroid_z     = rsp_cz_ff;
   assign rsp_over_volume    = rsp_over_ff;
   assign rsp_last_face      = rsp_last_ff;

   // a finished cell never overwrites one that is still playing out
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      complete |-> !out_active_ff || (out_face_ff == FACE_BACK))
      else $error("playout buffer overrun");

   // the six results of a cell go out on consecutive cycles
   a_results_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_face_ff != FACE_TOP) |-> $past(rsp_valid_ff))
      else $error("gap inside a cell's results");

endmodule

### src/slab_outflux_volume.sv
// ----------------------------------------------------------------------------
// slab_outflux_volume
// slab outflux volumes and slab centroids of one grid cell, six results
// per cell in the order top, bottom, right, left, front, back
// ----------------------------------------------------------------------------
// A cell is taken on a clock edge with start high and busy low. Its six
// results then appear one per cycle on the rsp_ ports, marked by rsp_valid,
// the first one once all six faces of the cell have been collected;
// rsp_last_face marks the back face. The receiver cannot stall: every
// result is on the ports for exactly one cycle. Cells are taken one at a
// time, paced by the single result port carrying six results per cell;
// busy is high while a cell's faces issue and low from its back face on.
// The csr_ port writes time_step and cell sizes; write only while no cell
// is in flight, and allow 4 cycles after a write before the next start so
// the derived face areas and cell volume have settled.
// ----------------------------------------------------------------------------
module slab_outflux_volume
   import sov_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   // cell transfer
   input  logic                   start,
   output logic                   busy,
   input  logic [DATA_WIDTH-1:0]  req_u_low_face,
   input  logic [DATA_WIDTH-1:0]  req_u_high_face,
   input  logic [DATA_WIDTH-1:0]  req_v_low_face,
   input  logic [DATA_WIDTH-1:0]  req_v_high_face,
   input  logic [DATA_WIDTH-1:0]  req_w_low_face,
   input  logic [DATA_WIDTH-1:0]  req_w_high_face,

   // result strobe and payload
   output logic                   rsp_valid,
   output logic [2:0]             rsp_face_index,
   output logic [DATA_WIDTH-2:0]  rsp_outflux_volume,
   output logic [DATA_WIDTH-1:0]  rsp_centroid_x,
   output logic [DATA_WIDTH-1:0]  rsp_centroid_y,
   output logic [DATA_WIDTH-1:0]  rsp_centroid_z,
   output logic                   rsp_over_volume,
   output logic                   rsp_last_face,

   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_WIDTH-2:0]  csr_wdata
);

   // configuration and its products
   logic [DATA_WIDTH-2:0] time_step;
   logic [DATA_WIDTH-2:0] size_x, size_y, size_z;
   logic [DATA_WIDTH-2:0] area_xz, area_yz, area_xy;
   logic [DATA_WIDTH-2:0] volume;

   // per-face stream out of the multiply pipeline
   face_tag_type          face_tag;
   logic [DATA_WIDTH-2:0] face_depth;
   logic [DATA_WIDTH-2:0] face_flux;

   // registers plus area and volume multipliers, rebuilt after every write
   sov_cfg #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .time_step (time_step),
      .size_x    (size_x),
      .size_y    (size_y),
      .size_z    (size_z),
      .area_xz   (area_xz),
      .area_yz   (area_yz),
      .area_xy   (area_xy),
      .volume    (volume)
   );

   // one face per cycle: magnitude, depth multiply, flux multiply
   sov_face_pipe #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_face_pipe (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .u_low_face  (req_u_low_face),
      .u_high_face (req_u_high_face),
      .v_low_face  (req_v_low_face),
      .v_high_face (req_v_high_face),
      .w_low_face  (req_w_low_face),
      .w_high_face (req_w_high_face),
      .time_step   (time_step),
      .area_xz     (area_xz),
      .area_yz     (area_yz),
      .area_xy     (area_xy),
      .out_tag     (face_tag),
      .out_depth   (face_depth),
      .out_flux    (face_flux)
   );

   // whole-cell total and flag, then playout with centroids
   sov_collect #(.DATA_WIDTH(DATA_WIDTH)) u_collect (
      .clock              (clock),
      .reset              (reset),
      .in_tag             (face_tag),
      .in_depth           (face_depth),
      .in_flux            (face_flux),
      .volume             (volume),
      .size_x             (size_x),
      .size_y             (size_y),
      .size_z             (size_z),
      .rsp_valid          (rsp_valid),
      .rsp_face_index     (rsp_face_index),
      .rsp_outflux_volume (rsp_outflux_volume),
      .rsp_centroid_x     (rsp_centroid_x),
      .rsp_centroid_y     (rsp_centroid_y),
      .rsp_centroid_z     (rsp_centroid_z),
      .rsp_over_volume    (rsp_over_volume),
      .rsp_last_face      (rsp_last_face)
   );

endmodule

### dv/slab_outflux_volume_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_outflux_volume_tb
// self-checking bench for the slab outflux volume block: cells go in through
// the start/busy port, every face result is checked field by field against a
// fixed-point prediction made when the cell transfer happens
// ----------------------------------------------------------------------------
module slab_outflux_volume_tb;
   import sov_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam logic [63:0] QMAX = (64'd1 << (DW - 1)) - 1;
   localparam int CSR_SETTLE    = 4;      // derived areas settle after a write
   localparam int DRAIN_SETTLE  = 4;      // quiet cycles after the last face
   localparam int RANDOM_CELLS  = 480;
   localparam int MAX_REPORTS   = 40;
   localparam realtime LIMIT_NS = 2_000_000;

   // one cell: the six face velocities
   typedef struct {
      logic [DW-1:0] u_lo, u_hi, v_lo, v_hi, w_lo, w_hi;
   } cell_type;

   // one face result as the block should present it
   typedef struct {
      face_type      face;
      logic [DW-2:0] volume;
      logic [DW-1:0] cx, cy, cz;
      logic          over;
      logic          last;
   } face_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [DW-1:0] req_u_low_face  = '0;
   logic [DW-1:0] req_u_high_face = '0;
   logic [DW-1:0] req_v_low_face  = '0;
   logic [DW-1:0] req_v_high_face = '0;
   logic [DW-1:0] req_w_low_face  = '0;
   logic [DW-1:0] req_w_high_face = '0;
   logic          rsp_valid;
   logic [2:0]    rsp_face_index;
   logic [DW-2:0] rsp_outflux_volume;
   logic [DW-1:0] rsp_centroid_x;
   logic [DW-1:0] rsp_centroid_y;
   logic [DW-1:0] rsp_centroid_z;
   logic          rsp_over_volume;
   logic          rsp_last_face;
   logic          csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_TIME_STEP;
   logic [DW-2:0] csr_wdata = '0;

   // geometry as the block holds it, tracked at each register write
   logic [DW-2:0] cfg_time_step = 31'd65536;
   logic [DW-2:0] cfg_size_x    = 31'd65536;
   logic [DW-2:0] cfg_size_y    = 31'd65536;
   logic [DW-2:0] cfg_size_z    = 31'd65536;

   face_result_type expected_faces[$];
   int unsigned  cells_sent     = 0;
   int unsigned  faces_checked  = 0;
   int unsigned  geometry_sets  = 0;
   int unsigned  over_seen      = 0;
   int unsigned  errors         = 0;
   bit           no_idle        = 1'b0;

   slab_outflux_volume dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_u_low_face     (req_u_low_face),
      .req_u_high_face    (req_u_high_face),
      .req_v_low_face     (req_v_low_face),
      .req_v_high_face    (req_v_high_face),
      .req_w_low_face     (req_w_low_face),
      .req_w_high_face    (req_w_high_face),
      .rsp_valid          (rsp_valid),
      .rsp_face_index     (rsp_face_index),
      .rsp_outflux_volume (rsp_outflux_volume),
      .rsp_centroid_x     (rsp_centroid_x),
      .rsp_centroid_y     (rsp_centroid_y),
      .rsp_centroid_z     (rsp_centroid_z),
      .rsp_over_volume    (rsp_over_volume),
      .rsp_last_face      (rsp_last_face),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // fixed-point prediction
   // ---------------------------------------------------------------------

   // exact product of two non-negative values, truncated by the fraction
   // bits and clipped at the largest positive value
   function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      logic [127:0] shifted;
      prod    = {64'd0, a} * {64'd0, b};
      shifted = prod >> FB;
      if (shifted > {64'd0, QMAX}) return QMAX;
      return shifted[63:0];
   endfunction

   // slab depth: high faces take +v, low faces take -v, never below zero
   function automatic logic [63:0] slab_depth(input logic [DW-1:0] vel, input bit high_face);
      logic [DW-1:0] neg_v;
      logic [63:0]   mag;
      bit            neg;
      neg   = vel[DW-1];
      neg_v = -vel;
      mag   = 64'(neg ? neg_v : vel);   // most negative value gives exactly 2^31
      if (vel == '0 || neg == high_face) return 64'd0;
      return fixed_mul(mag, 64'(cfg_time_step));
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > QMAX) ? QMAX : s;
   endfunction

   // six expected faces of one cell, queued in result order
   function automatic void predict_cell_faces(input cell_type c);
      logic [63:0]   depth_of [NUM_FACES];
      logic [63:0]   flux [NUM_FACES];
      logic [DW-1:0] half [NUM_FACES];
      logic [63:0]   area_xz, area_xy, area_yz, cell_volume, total;
      logic [DW-1:0] rx, ry, rz;
      logic [DW-1:0] hsx, hsy, hsz;
      face_result_type r;
      area_xz     = fixed_mul(64'(cfg_size_x), 64'(cfg_size_z));
      area_xy     = fixed_mul(64'(cfg_size_x), 64'(cfg_size_y));
      area_yz     = fixed_mul(64'(cfg_size_y), 64'(cfg_size_z));
      cell_volume = fixed_mul(area_xy, 64'(cfg_size_z));
      hsx         = {2'b00, cfg_size_x[DW-2:1]};
      hsy         = {2'b00, cfg_size_y[DW-2:1]};
      hsz         = {2'b00, cfg_size_z[DW-2:1]};
      depth_of[FACE_TOP]    = slab_depth(c.v_hi, 1'b1);
      depth_of[FACE_BOTTOM] = slab_depth(c.v_lo, 1'b0);
      depth_of[FACE_RIGHT]  = slab_depth(c.u_hi, 1'b1);
      depth_of[FACE_LEFT]   = slab_depth(c.u_lo, 1'b0);
      depth_of[FACE_FRONT]  = slab_depth(c.w_hi, 1'b1);
      depth_of[FACE_BACK]   = slab_depth(c.w_lo, 1'b0);
      flux[FACE_TOP]    = fixed_mul(depth_of[FACE_TOP], area_xz);
      flux[FACE_BOTTOM] = fixed_mul(depth_of[FACE_BOTTOM], area_xz);
      flux[FACE_RIGHT]  = fixed_mul(depth_of[FACE_RIGHT], area_yz);
      flux[FACE_LEFT]   = fixed_mul(depth_of[FACE_LEFT], area_yz);
      flux[FACE_FRONT]  = fixed_mul(depth_of[FACE_FRONT], area_xy);
      flux[FACE_BACK]   = fixed_mul(depth_of[FACE_BACK], area_xy);
      total = 64'd0;
      for (int i = 0; i < NUM_FACES; i++) begin
         total   = sat_add(total, flux[i]);
         half[i] = depth_of[i][DW:1];
      end
      rx = half[FACE_LEFT] - half[FACE_RIGHT];
      ry = half[FACE_BOTTOM] - half[FACE_TOP];
      rz = half[FACE_BACK] - half[FACE_FRONT];
      for (int i = 0; i < NUM_FACES; i++) begin
         r.face   = face_type'(i);
         r.volume = flux[i][DW-2:0];
         r.cx     = rx;
         r.cy     = ry;
         r.cz     = rz;
         case (r.face)
            FACE_TOP:    r.cy = hsy - half[i];
            FACE_BOTTOM: r.cy = half[i] - hsy;
            FACE_RIGHT:  r.cx = hsx - half[i];
            FACE_LEFT:   r.cx = half[i] - hsx;
            FACE_FRONT:  r.cz = hsz - half[i];
            default:     r.cz = half[i] - hsz;
         endcase
         r.over = (total > cell_volume);
         r.last = (r.face == FACE_BACK);
         expected_faces = {expected_faces, r};
      end
   endfunction

   // ---------------------------------------------------------------------
   // result checking: every strobe pops the oldest expected face
   // ---------------------------------------------------------------------

   function automatic void report_field(input string field, input face_type face,
                                        input logic [63:0] want, input logic [63:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t ns: face %0d %s mismatch, expected %h, actual %h",
                  $time, face, field, want, got);
   endfunction

   always @(posedge clock) begin : face_checker
      face_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_faces.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t ns: unexpected face result, expected none, actual face %0d",
                        $time, rsp_face_index);
         end else begin
            want = expected_faces.pop_front();
            faces_checked++;
            if (want.over) over_seen++;
            if (rsp_face_index !== want.face)
               report_field("face_index", want.face, 64'(want.face), 64'(rsp_face_index));
            if (rsp_outflux_volume !== want.volume)
               report_field("outflux_volume", want.face, 64'(want.volume),
                            64'(rsp_outflux_volume));
            if (rsp_centroid_x !== want.cx)
               report_field("centroid_x", want.face, 64'(want.cx), 64'(rsp_centroid_x));
            if (rsp_centroid_y !== want.cy)
               report_field("centroid_y", want.face, 64'(want.cy), 64'(rsp_centroid_y));
            if (rsp_centroid_z !== want.cz)
               report_field("centroid_z", want.face, 64'(want.cz), 64'(rsp_centroid_z));
            if (rsp_over_volume !== want.over)
               report_field("over_volume", want.face, 64'(want.over), 64'(rsp_over_volume));
            if (rsp_last_face !== want.last)
               report_field("last_face", want.face, 64'(want.last), 64'(rsp_last_face));
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // idle gaps: mostly none, some landing inside the busy window, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (no_idle || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 8);
      return $urandom_range(9, 30);
   endfunction

   // one cell transfer: start stays high until an edge with busy low
   task automatic send_cell(input cell_type c);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_u_low_face  <= c.u_lo;
      req_u_high_face <= c.u_hi;
      req_v_low_face  <= c.v_lo;
      req_v_high_face <= c.v_hi;
      req_w_low_face  <= c.w_lo;
      req_w_high_face <= c.w_hi;
      do @(posedge clock); while (busy !== 1'b0);
      // transfer happened at this edge
      predict_cell_faces(c);
      cells_sent++;
   endtask

   // sender holds off until every expected face has come back
   task automatic wait_for_results();
      start <= 1'b0;
      while (expected_faces.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   // writes all four registers back to back; only called with nothing in flight
   task automatic write_cell_geometry(input logic [DW-2:0] ts, input logic [DW-2:0] sx,
                                      input logic [DW-2:0] sy, input logic [DW-2:0] sz);
      reg_index_type idx [4];
      logic [DW-2:0] val [4];
      idx = '{REG_TIME_STEP, REG_CELL_SIZE_X, REG_CELL_SIZE_Y, REG_CELL_SIZE_Z};
      val = '{ts, sx, sy, sz};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we        <= 1'b0;
      cfg_time_step = ts;
      cfg_size_x    = sx;
      cfg_size_y    = sy;
      cfg_size_z    = sz;
      geometry_sets++;
      repeat (CSR_SETTLE) @(posedge clock);
   endtask

   function automatic cell_type cell_of(input logic [DW-1:0] ul, input logic [DW-1:0] uh,
                                        input logic [DW-1:0] vl, input logic [DW-1:0] vh,
                                        input logic [DW-1:0] wl, input logic [DW-1:0] wh);
      cell_type c;
      c.u_lo = ul; c.u_hi = uh;
      c.v_lo = vl; c.v_hi = vh;
      c.w_lo = wl; c.w_hi = wh;
      return c;
   endfunction

   function automatic cell_type uniform_cell(input logic [DW-1:0] v);
      return cell_of(v, v, v, v, v, v);
   endfunction

   // velocities: mostly a few cells per step so the volume flag toggles,
   // some full range for bit coverage and saturation, some corner values
   function automatic logic [DW-1:0] pick_velocity();
      int small_v;
      case ($urandom_range(19)) inside
         0:       return '0;
         1:       return {1'b1, {(DW-1){1'b0}}};
         2:       return {1'b0, {(DW-1){1'b1}}};
         3:       return '1;
         4, 5, 6: return DW'($urandom());
         default: begin
            small_v = int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
            return DW'(small_v);
         end
      endcase
   endfunction

   function automatic cell_type random_cell();
      return cell_of(pick_velocity(), pick_velocity(), pick_velocity(),
                     pick_velocity(), pick_velocity(), pick_velocity());
   endfunction

   function automatic logic [DW-2:0] nonzero_size(input logic [DW-2:0] s);
      return (s == '0) ? 31'd1 : s;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // field extremes under the reset geometry (all registers 1.0)
   task automatic test_reset_geometry();
      send_cell(uniform_cell(32'h0000_0000));
      send_cell(uniform_cell(32'h0001_0000));   // +1.0: high faces flow out
      send_cell(uniform_cell(32'hFFFF_0000));   // -1.0: low faces flow out
      send_cell(uniform_cell(32'h7FFF_FFFF));   // largest positive, saturates
      send_cell(uniform_cell(32'h8000_0000));   // most negative, exact magnitude
      send_cell(uniform_cell(32'hFFFF_FFFF));   // one lsb inward/outward
      send_cell(uniform_cell(32'h0000_0001));
      send_cell(cell_of(32'hFFFE_0000, 32'h0002_0000, 32'h0000_8000,
                        32'hFFFF_8000, 32'hFFFF_C000, 32'h0000_4000));
      wait_for_results();
   endtask

   // register extremes: zero timestep, largest values, smallest cell sizes
   task automatic test_register_extremes();
      write_cell_geometry(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_cell(uniform_cell(32'h7FFF_FFFF));
      send_cell(uniform_cell(32'h8000_0000));
      wait_for_results();
      write_cell_geometry(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_cell(uniform_cell(32'h7FFF_FFFF));
      send_cell(uniform_cell(32'h8000_0000));
      send_cell(cell_of(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000,
                        32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0000));
      wait_for_results();
      write_cell_geometry(31'h7FFF_FFFF, 31'd1, 31'd1, 31'd1);
      send_cell(uniform_cell(32'h7FFF_FFFF));
      send_cell(uniform_cell(32'h8000_0000));
      send_cell(uniform_cell(32'h0000_0001));
      wait_for_results();
      // uneven cell, half timestep: small flows below and above the volume
      write_cell_geometry(31'h0000_8000, 31'h0001_0000, 31'h0002_0000, 31'h0000_8000);
      send_cell(cell_of(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000,
                        32'h0000_4000, 32'h0000_0000, 32'h0000_0000));
      send_cell(cell_of(32'hFFFC_0000, 32'h0004_0000, 32'hFFFC_0000,
                        32'h0004_0000, 32'hFFFC_0000, 32'h0004_0000));
      send_cell(cell_of(32'h0004_0000, 32'hFFFC_0000, 32'h0004_0000,
                        32'hFFFC_0000, 32'h0004_0000, 32'hFFFC_0000));
      wait_for_results();
   endtask

   // random cells in phases, each phase under a fresh random geometry
   task automatic test_random_cells();
      int unsigned sent;
      int unsigned phase_cells;
      logic [DW-2:0] ts, sx, sy, sz;
      sent = 0;
      while (sent < RANDOM_CELLS) begin
         case ($urandom_range(3))
            0: begin   // realistic: fractions of a cell per step
               ts = (DW-1)'($urandom_range(1 << 12, 1 << 16));
               sx = (DW-1)'($urandom_range(1 << 14, 3 << 16));
               sy = (DW-1)'($urandom_range(1 << 14, 3 << 16));
               sz = (DW-1)'($urandom_range(1 << 14, 3 << 16));
            end
            1: begin   // full register range
               ts = (DW-1)'($urandom() >> 1);
               sx = nonzero_size((DW-1)'($urandom() >> 1));
               sy = nonzero_size((DW-1)'($urandom() >> 1));
               sz = nonzero_size((DW-1)'($urandom() >> 1));
            end
            2: begin   // tiny cells, any timestep
               ts = (DW-1)'($urandom() >> 1);
               sx = (DW-1)'($urandom_range(1, 1 << 12));
               sy = (DW-1)'($urandom_range(1, 1 << 12));
               sz = (DW-1)'($urandom_range(1, 1 << 12));
            end
            default: begin
               ts = (DW-1)'($urandom_range(0, 1 << 17));
               sx = 31'h0001_0000;
               sy = 31'h0001_0000;
               sz = 31'h0001_0000;
            end
         endcase
         write_cell_geometry(ts, sx, sy, sz);
         no_idle     = ($urandom_range(3) == 0);
         phase_cells = $urandom_range(20, 80);
         if (phase_cells > RANDOM_CELLS - sent) phase_cells = RANDOM_CELLS - sent;
         repeat (phase_cells) begin
            send_cell(random_cell());
            sent++;
            // now and then let the pipeline run dry mid phase
            if ($urandom_range(39) == 0) wait_for_results();
         end
         wait_for_results();
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_register_extremes();
      test_random_cells();
      wait_for_results();
      $display("covered %0d cells in %0d register settings, %0d face results checked",
               cells_sent, geometry_sets, faces_checked);
      $display("%0d faces carried the over-volume flag, %0d mismatches", over_seen, errors);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog: a hung handshake or missing faces end the run here
   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d faces outstanding", expected_faces.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### sim.f
src/sov_pkg.sv
src/sov_qmul.sv
src/sov_cfg.sv
src/sov_face_pipe.sv
src/sov_collect.sv
src/slab_outflux_volume.sv
dv/slab_outflux_volume_tb.sv
